// ----- rtl/atdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdq_pkg
// Shared constants and types of the addressed task dispatch queue.
// ----------------------------------------------------------------------------
package atdq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TASK_BITS   = 16;
   localparam int PROMPT_BITS = 32;
   localparam int NODE_BITS   = 11;
   localparam int MSG_BITS    = 12;
   localparam int ACTION_BITS = 3;
   localparam int QCOUNT_BITS = 5;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS = TASK_BITS + PROMPT_BITS;

   localparam logic [NODE_BITS-1:0] NODE_ID_RESET = NODE_BITS'(1);
   localparam logic [NODE_BITS-1:0] BROADCAST_ID  = '0;

   localparam logic [MSG_BITS-1:0] MSG_EMERGENCY = 12'h001;
   localparam logic [MSG_BITS-1:0] MSG_STOP      = 12'h010;
   localparam logic [MSG_BITS-1:0] MSG_REPLACE   = 12'h020;
   localparam logic [MSG_BITS-1:0] MSG_NEW       = 12'h100;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_IGNORED   = 3'd0,
      ACT_STARTED   = 3'd1,
      ACT_QUEUED    = 3'd2,
      ACT_STOPPED   = 3'd3,
      ACT_REPLACED  = 3'd4,
      ACT_EMERGENCY = 3'd5,
      ACT_COMPLETED = 3'd6,
      ACT_DROPPED   = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

endpackage

// ----- rtl/atdq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module atdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/addressed_task_dispatch_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_task_dispatch_queue_core
// Node-addressed task dispatcher with a FIFO of waiting tasks held in RAM.
// ----------------------------------------------------------------------------
// An accepted request is handled as follows: in the accept cycle the head of the
// waiting-task RAM is read, and in the following cycle the frame is decoded,
// the running task is updated, the RAM is written when a task is queued, and
// the single response is loaded into the output register. The next request
// can be taken in the cycle right after the decode cycle whenever the
// response register is empty or being transferred; no new request is taken
// while one is in flight. The node ID register (reset 1) is written
// through the csr channel, which is always ready; a write is expected only
// while no request is in flight. Queue entries need no clearing after reset.
// ----------------------------------------------------------------------------
module addressed_task_dispatch_queue_core (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [atdq_pkg::NODE_BITS-1:0]         req_dest_id,
   input  logic [atdq_pkg::MSG_BITS-1:0]          req_msg_type,
   input  logic [atdq_pkg::TASK_BITS-1:0]         req_task_id,
   input  logic [atdq_pkg::PROMPT_BITS-1:0]       req_prompt_ref,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [atdq_pkg::ACTION_BITS-1:0]       rsp_action,
   output logic                                   rsp_busy_res,
   output logic [atdq_pkg::TASK_BITS-1:0]         rsp_current_task,
   output logic [atdq_pkg::PROMPT_BITS-1:0]       rsp_current_prompt,
   output logic [atdq_pkg::QCOUNT_BITS-1:0]       rsp_queue_count,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [atdq_pkg::NODE_BITS-1:0]         csr_data
);

   localparam int PB = atdq_pkg::PTR_BITS;
   localparam int CB = atdq_pkg::COUNT_BITS;
   localparam int TB = atdq_pkg::TASK_BITS;
   localparam int RB = atdq_pkg::PROMPT_BITS;

   atdq_pkg::state_type state_ff, state_in;

   logic [atdq_pkg::NODE_BITS-1:0] node_id_ff;

   // Registered request.
   logic                           func_ff;
   logic [atdq_pkg::NODE_BITS-1:0] target_ff;
   logic [atdq_pkg::MSG_BITS-1:0]  msg_ff;
   logic [TB-1:0]                  task_ff;
   logic [RB-1:0]                  prompt_ff;

   // Dispatcher state.
   logic          working_ff, working_in;
   logic [TB-1:0] active_task_ff, active_task_in;
   logic [RB-1:0] active_prompt_ff, active_prompt_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CB-1:0] count_ff, count_in;

   // Response register.
   logic                             rsp_valid_ff;
   atdq_pkg::action_type             action_ff, action_in;

   logic                             req_accept;
   logic                             ram_wr_en;
   logic [atdq_pkg::ENTRY_BITS-1:0]  ram_rd_data;
   logic [TB-1:0]                    head_task;
   logic [RB-1:0]                    head_prompt;
   logic [63:0]                      count_wide;

   function automatic logic [PB-1:0] next_slot(input logic [PB-1:0] p);
      logic [PB-1:0] result;
      if (p == PB'(atdq_pkg::QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = p + PB'(1);
      end
      return result;
   endfunction

   // A response register that is empty at accept time stays empty through
   // the decode cycle, since only that cycle loads it.
   assign req_stall  = (state_ff != atdq_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign head_task   = ram_rd_data[atdq_pkg::ENTRY_BITS-1 -: TB];
   assign head_prompt = ram_rd_data[RB-1:0];

   atdq_ram #(
      .WIDTH (atdq_pkg::ENTRY_BITS),
      .DEPTH (atdq_pkg::QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data ({task_ff, prompt_ff}),
      .rd_en   (req_accept),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic addressed;
      logic own;
      logic advance;
      addressed        = (target_ff == node_id_ff) || (target_ff == atdq_pkg::BROADCAST_ID);
      own              = (target_ff == node_id_ff);
      advance          = 1'b0;
      state_in         = state_ff;
      working_in       = working_ff;
      active_task_in   = active_task_ff;
      active_prompt_in = active_prompt_ff;
      rd_ptr_in        = rd_ptr_ff;
      wr_ptr_in        = wr_ptr_ff;
      count_in         = count_ff;
      action_in        = action_ff;
      ram_wr_en        = 1'b0;

      case (state_ff)
         atdq_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = atdq_pkg::S_EXEC;
            end
         end
         atdq_pkg::S_EXEC: begin
            state_in  = atdq_pkg::S_IDLE;
            action_in = atdq_pkg::ACT_IGNORED;
            if (func_ff) begin
               if (working_ff) begin
                  advance   = 1'b1;
                  action_in = atdq_pkg::ACT_COMPLETED;
               end
            end else if (addressed) begin
               case (msg_ff)
                  atdq_pkg::MSG_EMERGENCY: begin
                     working_in       = 1'b0;
                     active_task_in   = '0;
                     active_prompt_in = '0;
                     rd_ptr_in        = '0;
                     wr_ptr_in        = '0;
                     count_in         = '0;
                     action_in        = atdq_pkg::ACT_EMERGENCY;
                  end
                  atdq_pkg::MSG_NEW: begin
                     if (!working_ff) begin
                        working_in       = 1'b1;
                        active_task_in   = task_ff;
                        active_prompt_in = prompt_ff;
                        action_in        = atdq_pkg::ACT_STARTED;
                     end else if (count_ff < CB'(atdq_pkg::QUEUE_DEPTH)) begin
                        ram_wr_en = 1'b1;
                        wr_ptr_in = next_slot(wr_ptr_ff);
                        count_in  = count_ff + CB'(1);
                        action_in = atdq_pkg::ACT_QUEUED;
                     end else begin
                        action_in = atdq_pkg::ACT_DROPPED;
                     end
                  end
                  atdq_pkg::MSG_STOP: begin
                     if (own && working_ff && (task_ff == active_task_ff)) begin
                        advance   = 1'b1;
                        action_in = atdq_pkg::ACT_STOPPED;
                     end
                  end
                  atdq_pkg::MSG_REPLACE: begin
                     if (own && working_ff) begin
                        active_prompt_in = prompt_ff;
                        action_in        = atdq_pkg::ACT_REPLACED;
                     end
                  end
                  default: begin
                     action_in = atdq_pkg::ACT_IGNORED;
                  end
               endcase
            end

            // Ending a task pulls the queue head, which the RAM read at accept.
            if (advance) begin
               if (count_ff != '0) begin
                  working_in       = 1'b1;
                  active_task_in   = head_task;
                  active_prompt_in = head_prompt;
                  rd_ptr_in        = next_slot(rd_ptr_ff);
                  count_in         = count_ff - CB'(1);
               end else begin
                  working_in       = 1'b0;
                  active_task_in   = '0;
                  active_prompt_in = '0;
               end
            end
         end
         default: begin
            state_in = atdq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= atdq_pkg::S_IDLE;
         node_id_ff       <= atdq_pkg::NODE_ID_RESET;
         working_ff       <= 1'b0;
         active_task_ff   <= '0;
         active_prompt_ff <= '0;
         rd_ptr_ff        <= '0;
         wr_ptr_ff        <= '0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         action_ff        <= atdq_pkg::ACT_IGNORED;
      end else begin
         state_ff         <= state_in;
         working_ff       <= working_in;
         active_task_ff   <= active_task_in;
         active_prompt_ff <= active_prompt_in;
         rd_ptr_ff        <= rd_ptr_in;
         wr_ptr_ff        <= wr_ptr_in;
         count_ff         <= count_in;
         action_ff        <= action_in;
         if (csr_valid && csr_ready) begin
            node_id_ff <= csr_data;
         end
         if (state_ff == atdq_pkg::S_EXEC) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff   <= req_func;
         target_ff <= req_dest_id;
         msg_ff    <= req_msg_type;
         task_ff   <= req_task_id;
         prompt_ff <= req_prompt_ref;
      end
   end

   assign count_wide = 64'(count_ff);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = action_ff;
   assign rsp_busy_res       = working_ff;
   assign rsp_current_task   = active_task_ff;
   assign rsp_current_prompt = active_prompt_ff;
   assign rsp_queue_count    = count_wide[atdq_pkg::QCOUNT_BITS-1:0];

endmodule
